// ===== hdl/mes_pkg.sv =====
// Shared types, codes and constants for the MIDI event scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mes_pkg;

	localparam int TABLE_DEPTH_DEF = 32;

	localparam logic [7:0] NOTE_MAX = 8'd127;
	localparam logic [7:0] VALUE_MAX = 8'd127;
	localparam logic [7:0] CHAN_MAX = 8'd16;

	typedef enum logic [1:0] {
		OP_POST = 2'd0,
		OP_PROCESS = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	localparam logic [1:0] EV_NOTE_ON = 2'd0;
	localparam logic [1:0] EV_NOTE_OFF = 2'd1;
	localparam logic [1:0] EV_CC = 2'd2;
	localparam logic [1:0] EV_OTHER = 2'd3;

	localparam logic [2:0] KIND_NOTE_ON = 3'd0;
	localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
	localparam logic [2:0] KIND_CC = 3'd2;
	localparam logic [2:0] KIND_NONE = 3'd3;
	localparam logic [2:0] KIND_FULL = 3'd4;

	typedef struct packed {
		logic [4:0] channel;
		logic [6:0] value;
		logic [6:0] note;
		logic [1:0] ev_type;
	} msg_t;

	typedef struct packed {
		logic [31:0] due;
		msg_t msg;
	} entry_t;

	// first field in the highest bits
	typedef struct packed {
		logic [32:0] buffer_offset;
		logic [4:0] out_channel;
		logic [6:0] out_value;
		logic [6:0] out_note;
		logic [2:0] out_kind;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POST2,
		ST_P_RD,
		ST_P_CHK,
		ST_P_MV,
		ST_C_RD,
		ST_C_CHK,
		ST_FLUSH
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/midi_event_scheduler_unit.sv =====
// Top level of the MIDI event scheduler: sequencer, compare/offset unit, output beat.
// Post: writes the event; a note-on also writes its note-off in ST_POST2; a full table
// writes nothing and returns a status beat. Process: removes due entries, emitting those
// not EV_OTHER; clear: emits a note-off per note entry; either ends with a final beat.
// A waiting beat stalls the scan. Not ready until the last beat is in the output reg.
// arst_n empties the table and output; slot contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module midi_event_scheduler_unit
	import mes_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// opcode, event_type, note_or_control, velocity_or_value, channel_number,
	// due_time, note_length, window_end, window_length, 4 zero bits
	input  wire logic [135:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// out_kind, out_note, out_value, out_channel, buffer_offset, 1 zero bit
	output logic [55:0] m_axis_tdata,
	output logic m_axis_tlast
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW:0] DEPTH_C = (CW + 1)'(TABLE_DEPTH);

	state_t state_q, state_nx;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [31:0] wend_q;
	logic [15:0] wlen_q;
	entry_t off_q;
	result_t pend_q;
	logic pend_valid_q;
	result_t out_q;
	logic out_valid_q, out_last_q;

	logic wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	entry_t wr_data, rd_data;

	// input fields
	logic [1:0] in_op, in_type;
	logic [7:0] in_note, in_val, in_ch;
	logic [31:0] in_due, in_wend;
	logic [23:0] in_len;
	logic [15:0] in_wlen;

	assign in_op = s_axis_tdata[1:0];
	assign in_type = s_axis_tdata[3:2];
	assign in_note = s_axis_tdata[11:4];
	assign in_val = s_axis_tdata[19:12];
	assign in_ch = s_axis_tdata[27:20];
	assign in_due = s_axis_tdata[59:28];
	assign in_len = s_axis_tdata[83:60];
	assign in_wend = s_axis_tdata[115:84];
	assign in_wlen = s_axis_tdata[131:116];

	logic s_fire, out_free, table_full, clr_last;
	logic [AW-1:0] last_idx;
	msg_t post_msg;
	logic [32:0] end_sum;
	logic [32:0] offset;
	logic is_due, emit, stall, push;
	result_t new_res, push_res;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	assign table_full = ({1'b0, count_q} + ((in_type == EV_NOTE_ON) ? (CW + 1)'(2) : (CW + 1)'(1)))
		> DEPTH_C;
	assign last_idx = AW'(count_q - CW'(1));
	assign clr_last = ({1'b0, idx_q} + (CW + 1)'(1)) == {1'b0, count_q};

	always_comb begin
		post_msg.ev_type = in_type;
		post_msg.note = (in_note > NOTE_MAX) ? 7'd127 : in_note[6:0];
		post_msg.value = (in_val > VALUE_MAX) ? 7'd127 : in_val[6:0];
		post_msg.channel = (in_ch > CHAN_MAX) ? 5'd16 : in_ch[4:0];
	end

	assign end_sum = {1'b0, in_due} + {9'b0, in_len};

	// shared compare / offset unit
	assign is_due = rd_data.due <= wend_q;
	assign offset = {1'b0, rd_data.due} - {1'b0, wend_q} + {17'b0, wlen_q};

	always_comb begin
		new_res.out_kind = {1'b0, rd_data.msg.ev_type};
		new_res.out_note = rd_data.msg.note;
		new_res.out_value = rd_data.msg.value;
		new_res.out_channel = rd_data.msg.channel;
		new_res.buffer_offset = offset;
		emit = 1'b0;
		if (state_q == ST_P_CHK) begin
			emit = is_due && (rd_data.msg.ev_type != EV_OTHER);
		end else if (state_q == ST_C_CHK) begin
			emit = (rd_data.msg.ev_type == EV_NOTE_ON) || (rd_data.msg.ev_type == EV_NOTE_OFF);
			new_res.out_kind = KIND_NOTE_OFF;
			new_res.out_value = '0;
			new_res.buffer_offset = '0;
		end
	end

	assign stall = emit && pend_valid_q && !out_free;

	always_comb begin
		push = (emit && pend_valid_q && out_free) || (state_q == ST_FLUSH && out_free);
		push_res = pend_q;
		if (state_q == ST_FLUSH && !pend_valid_q) begin
			push_res = '0;
			push_res.out_kind = KIND_NONE;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					unique case (opcode_t'(in_op))
						OP_POST: begin
							if (table_full) state_nx = ST_FLUSH;
							else if (in_type == EV_NOTE_ON) state_nx = ST_POST2;
						end
						OP_PROCESS: state_nx = (count_q == '0) ? ST_FLUSH : ST_P_RD;
						OP_CLEAR: state_nx = (count_q == '0) ? ST_FLUSH : ST_C_RD;
						OP_NONE: state_nx = ST_IDLE;
						default: state_nx = ST_IDLE;
					endcase
				end
			end
			ST_POST2: state_nx = ST_IDLE;
			ST_P_RD: state_nx = ST_P_CHK;
			ST_P_CHK: begin
				if (!stall) begin
					if (is_due) state_nx = ST_P_MV;
					else state_nx = (idx_q == '0) ? ST_FLUSH : ST_P_RD;
				end
			end
			ST_P_MV: state_nx = (idx_q == '0) ? ST_FLUSH : ST_P_RD;
			ST_C_RD: state_nx = ST_C_CHK;
			ST_C_CHK: begin
				if (!stall) state_nx = clr_last ? ST_FLUSH : ST_C_RD;
			end
			ST_FLUSH: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// table port control
	always_comb begin
		wr_en = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = '0;
		rd_addr = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				wr_en = s_fire && (in_op == OP_POST) && !table_full;
				wr_data.due = in_due;
				wr_data.msg = post_msg;
			end
			ST_POST2: begin
				wr_en = 1'b1;
				wr_data = off_q;
			end
			ST_P_CHK: begin
				if (is_due && !stall) rd_addr = last_idx;
			end
			ST_P_MV: begin
				wr_en = 1'b1;
				wr_addr = idx_q;
				wr_data = rd_data;
			end
			ST_P_RD, ST_C_RD, ST_C_CHK, ST_FLUSH: begin
				rd_addr = idx_q;
			end
			default: rd_addr = idx_q;
		endcase
	end

	mes_slot_ram #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (push) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			if (emit && !stall) pend_valid_q <= 1'b1;
			else if (state_q == ST_FLUSH && out_free) pend_valid_q <= 1'b0;
			if (state_q == ST_IDLE && s_fire && in_op == OP_POST) begin
				if (table_full) pend_valid_q <= 1'b1;
				else count_q <= count_q + CW'(1);
			end
			if (state_q == ST_POST2) count_q <= count_q + CW'(1);
			if (state_q == ST_P_MV) count_q <= count_q - CW'(1);
			if (state_q == ST_C_CHK && !stall && clr_last) count_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_fire) begin
			wend_q <= in_wend;
			wlen_q <= in_wlen;
			idx_q <= (in_op == OP_PROCESS) ? last_idx : '0;
			off_q <= {(end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0]), post_msg.channel, 7'd0,
				post_msg.note, EV_NOTE_OFF};
			pend_q <= result_t'({52'd0, KIND_FULL});
		end
		if (emit && !stall) pend_q <= new_res;
		if (state_q == ST_P_CHK && !stall && !is_due && idx_q != '0) idx_q <= idx_q - AW'(1);
		if (state_q == ST_P_MV && idx_q != '0) idx_q <= idx_q - AW'(1);
		if (state_q == ST_C_CHK && !stall) idx_q <= idx_q + AW'(1);
		if (push) begin
			out_q <= push_res;
			out_last_q <= (state_q == ST_FLUSH);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, out_q};
	assign m_axis_tlast = out_last_q;

endmodule
`default_nettype wire

// ===== hdl/mes_slot_ram.sv =====
// Event table storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module mes_slot_ram
	import mes_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic wr_en,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  wire entry_t wr_data,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	output entry_t rd_data
);

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== hdl/mes_checker.sv =====
// Port-level checker for the MIDI event scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mes_checker
	import mes_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic [135:0] s_axis_tdata,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [55:0] m_axis_tdata,
	input wire logic m_axis_tlast
);

	// beat held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat dropped before it was taken");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= KIND_FULL)
		else $error("output kind out of range");

	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] == KIND_NONE || m_axis_tdata[2:0] == KIND_FULL)
		|-> m_axis_tlast && m_axis_tdata[55:3] == '0)
		else $error("status beat not last or carries payload");

	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready
		&& (s_axis_tdata[1:0] == OP_PROCESS || s_axis_tdata[1:0] == OP_CLEAR)
		|=> !s_axis_tready)
		else $error("ready right after a process or clear beat");

endmodule

bind midi_event_scheduler_unit mes_checker u_mes_checker (.*);
`default_nettype wire
